// File: design/gbd_pkg.sv
// ---------------------------------------------------------------------------
// gbd_pkg : shared types and constants of the GRIB/BUFR message deframer
// Tags, message kinds, status codes and the queue entry type.
// ---------------------------------------------------------------------------
`default_nettype none
package gbd_pkg;

  localparam int unsigned LENGTH_BITS  = 32;
  localparam int unsigned HEADER_LIMIT = 32;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] TAG_GRIB = 32'h4752_4942;
  localparam logic [31:0] TAG_BUFR = 32'h4255_4652;
  localparam logic [31:0] TAG_TIDE = 32'h5449_4445;
  localparam logic [31:0] TAG_BUDG = 32'h4255_4447;
  localparam logic [7:0]  CHAR_7   = 8'h37;

  localparam logic [1:0] KIND_GRIB = 2'd0;
  localparam logic [1:0] KIND_BUFR = 2'd1;
  localparam logic [1:0] KIND_TIDE = 2'd2;
  localparam logic [1:0] KIND_BUDG = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TRL   = 3'd1;
  localparam logic [2:0] ST_BAD_ED    = 3'd2;
  localparam logic [2:0] ST_PREMATURE = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_HDR_LONG  = 3'd5;
  localparam logic [2:0] ST_NO_MSG    = 3'd6;
  localparam logic [2:0] ST_BAD_LEN   = 3'd7;

  localparam logic CFG_GRIB_EN = 1'b0;
  localparam logic CFG_BUFR_EN = 1'b1;

  typedef struct packed {
    logic       stream_end;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic grib_en;
    logic bufr_en;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/gbd_fifo.sv
// ---------------------------------------------------------------------------
// gbd_fifo : front request queue
// Accepts stream requests and holds them until the parser takes them.
// ---------------------------------------------------------------------------
`default_nettype none
module gbd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gbd_pkg::item_t in_item_i,
  output logic               deq_valid_o,
  input  wire logic          deq_pop_i,
  output gbd_pkg::item_t     deq_item_o
);

  gbd_pkg::item_t mem_q [gbd_pkg::FIFO_DEPTH];
  logic [gbd_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [gbd_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic push, pop;

  assign in_stall_o  = (cnt_q == gbd_pkg::FIFO_CNT_W'(gbd_pkg::FIFO_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign deq_valid_o = (cnt_q != '0);
  assign pop         = deq_pop_i && deq_valid_o;
  assign deq_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == gbd_pkg::FIFO_PTR_W'(gbd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == gbd_pkg::FIFO_PTR_W'(gbd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/gbd_parser.sv
// ---------------------------------------------------------------------------
// gbd_parser : back end of the deframer
// Hunts tags, parses headers, counts bodies and registers descriptors.
// ---------------------------------------------------------------------------
`default_nettype none
module gbd_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire gbd_pkg::cfg_t  cfg_i,
  input  wire logic           deq_valid_i,
  output logic                deq_pop_o,
  input  wire gbd_pkg::item_t deq_item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          msg_kind_o,
  output logic [7:0]          msg_edition_o,
  output logic [31:0]         msg_length_o,
  output logic [47:0]         msg_offset_o,
  output logic [2:0]          status_o
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_HEAD, PH_SKIP1, PH_SKIP2, PH_SKIP3,
    PH_S2LEN, PH_S3LEN, PH_S4LEN, PH_BODY
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] tag_q, tag_d;
  logic [47:0] cnt_q, cnt_d, start_q, start_d;
  logic [63:0] accum_q, accum_d;
  logic [23:0] slen_q, slen_d, left_q, left_d;
  logic [31:0] sum_q, sum_d;
  logic [7:0]  flags_q, flags_d, ed_q, ed_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  trl_q, trl_d;

  logic        ov_q, ov_d;
  logic [1:0]  ok_q, ok_d;
  logic [7:0]  oe_q, oe_d;
  logic [31:0] ol_q, ol_d;
  logic [47:0] oo_q, oo_d;
  logic [2:0]  os_q, os_d;

  logic        emit, em_zero;
  logic [2:0]  em_st;
  logic [31:0] em_len;
  logic [47:0] em_off;
  logic        st_req, sk_req, fs_req;
  logic [63:0] st_total;
  logic [1:0]  sk_which, fs_which;
  logic [23:0] sk_n, s_new, left_dec;
  logic [31:0] tag_sh;
  logic [47:0] pos;
  logic [48:0] nread;
  logic [7:0]  b;
  logic [29:0] mul120;
  logic [30:0] t120;

  function automatic phase_e fsec(input logic [1:0] which, input logic [1:0] kind,
                                  input logic [7:0] flags);
    if (kind >= gbd_pkg::KIND_TIDE || which == 2'd3) begin
      return PH_S4LEN;
    end else if (which == 2'd1 && flags[7]) begin
      return PH_S2LEN;
    end else if (kind == gbd_pkg::KIND_BUFR || flags[6]) begin
      return PH_S3LEN;
    end else begin
      return PH_S4LEN;
    end
  endfunction

  assign deq_pop_o = deq_valid_i && (!ov_q || !out_stall_i);
  assign b         = deq_item_i.data_byte;
  assign tag_sh    = {tag_q[23:0], b};
  assign pos       = cnt_q - start_q;
  assign nread     = {1'b0, pos} + 49'd1;
  assign s_new     = {slen_q[15:0], b};
  assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;
  // times 120 as 128 - 8
  assign mul120    = ({accum_q[22:0], 7'd0}) - ({4'd0, accum_q[22:0], 3'd0});
  assign t120      = {1'b0, mul120} + 31'd4;

  always_comb begin
    phase_d = phase_q; tag_d = tag_q; cnt_d = cnt_q; start_d = start_q;
    accum_d = accum_q; slen_d = slen_q; left_d = left_q; sum_d = sum_q;
    flags_d = flags_q; ed_d = ed_q; kind_d = kind_q; trl_d = trl_q;
    emit = 1'b0; em_zero = 1'b0; em_st = gbd_pkg::ST_OK; em_len = '0; em_off = start_q;
    st_req = 1'b0; st_total = '0; sk_req = 1'b0; sk_which = 2'd1; sk_n = '0;
    fs_req = 1'b0; fs_which = 2'd1;

    if (deq_pop_o) begin
      if (deq_item_i.stream_end) begin
        emit = 1'b1;
        if (phase_q == PH_HUNT) begin
          em_st = gbd_pkg::ST_NO_MSG; em_zero = 1'b1; em_off = cnt_q;
        end else begin
          em_st  = gbd_pkg::ST_PREMATURE;
          em_len = (phase_q == PH_BODY) ? accum_q[31:0] : '0;
        end
      end else begin
        cnt_d = cnt_q + 48'd1;
        if (phase_q == PH_HUNT) begin
          tag_d = tag_sh;
          if ((tag_sh == gbd_pkg::TAG_GRIB && cfg_i.grib_en) ||
              (tag_sh == gbd_pkg::TAG_BUFR && cfg_i.bufr_en) ||
              (tag_sh == gbd_pkg::TAG_TIDE && cfg_i.grib_en) ||
              (tag_sh == gbd_pkg::TAG_BUDG && cfg_i.grib_en)) begin
            if (tag_sh == gbd_pkg::TAG_GRIB && cfg_i.grib_en) kind_d = gbd_pkg::KIND_GRIB;
            else if (tag_sh == gbd_pkg::TAG_BUFR && cfg_i.bufr_en) kind_d = gbd_pkg::KIND_BUFR;
            else if (tag_sh == gbd_pkg::TAG_TIDE) kind_d = gbd_pkg::KIND_TIDE;
            else kind_d = gbd_pkg::KIND_BUDG;
            start_d = cnt_q - 48'd3;
            phase_d = PH_HEAD;
            accum_d = '0; slen_d = '0; sum_d = '0; flags_d = '0;
            ed_d = '0; trl_d = '0; left_d = '0;
          end
        end else begin
          if (b == gbd_pkg::CHAR_7) begin
            trl_d = (trl_q < 3'd4) ? trl_q + 3'd1 : trl_q;
          end else begin
            trl_d = '0;
          end
          case (phase_q)
            PH_HEAD: begin
              if (kind_q >= gbd_pkg::KIND_TIDE) begin
                if (pos <= 48'd6) begin
                  slen_d = s_new;
                  if (pos == 48'd6) begin
                    if ({8'd0, s_new} + 32'd7 > 32'(gbd_pkg::HEADER_LIMIT)) begin
                      emit = 1'b1; em_st = gbd_pkg::ST_HDR_LONG;
                    end else if (s_new < 24'd3) begin
                      emit = 1'b1; em_st = gbd_pkg::ST_BAD_LEN;
                    end else begin
                      sum_d = {8'd0, s_new};
                      sk_req = 1'b1; sk_which = 2'd1; sk_n = s_new - 24'd3;
                    end
                  end
                end
              end else if (pos <= 48'd6) begin
                accum_d = {accum_q[55:0], b};
              end else if (pos == 48'd7) begin
                ed_d = b;
                if (kind_q == gbd_pkg::KIND_GRIB) begin
                  if (b == 8'd1) begin
                    if (!accum_q[23]) begin
                      st_req = 1'b1; st_total = accum_q;
                    end else begin
                      slen_d = '0;
                    end
                  end else if (b == 8'd2) begin
                    accum_d = '0;
                  end else begin
                    emit = 1'b1; em_st = gbd_pkg::ST_BAD_ED;
                  end
                end else if (b >= 8'd2) begin
                  st_req = 1'b1; st_total = accum_q;
                end
              end else if (kind_q == gbd_pkg::KIND_GRIB && ed_q == 8'd2) begin
                accum_d = {accum_q[55:0], b};
                if (pos == 48'd15) begin
                  st_req = 1'b1; st_total = {accum_q[55:0], b};
                end
              end else if (kind_q == gbd_pkg::KIND_GRIB) begin
                if (pos <= 48'd10) begin
                  slen_d = s_new;
                end else if (pos == 48'd15) begin
                  flags_d = b;
                  if (slen_q < 24'd8) begin
                    emit = 1'b1; em_st = gbd_pkg::ST_BAD_LEN;
                  end else begin
                    sk_req = 1'b1; sk_which = 2'd1; sk_n = slen_q - 24'd8;
                  end
                end
              end else if (pos == 48'd11) begin
                flags_d = b;
                if (accum_q[23:0] < 24'd8) begin
                  emit = 1'b1; em_st = gbd_pkg::ST_BAD_LEN;
                end else begin
                  sum_d = {8'd0, accum_q[23:0]};
                  sk_req = 1'b1; sk_which = 2'd1; sk_n = accum_q[23:0] - 24'd8;
                end
              end
            end
            PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
              left_d = left_dec;
              if (left_dec == '0) begin
                fs_req = 1'b1;
                fs_which = (phase_q == PH_SKIP1) ? 2'd1 : ((phase_q == PH_SKIP2) ? 2'd2 : 2'd3);
              end
            end
            PH_S2LEN, PH_S3LEN, PH_S4LEN: begin
              slen_d = s_new;
              left_d = left_dec;
              if (left_dec == '0) begin
                if (phase_q == PH_S4LEN) begin
                  if (kind_q == gbd_pkg::KIND_GRIB) begin
                    if (s_new < 24'd120) begin
                      if (t120 < {7'd0, s_new}) begin
                        emit = 1'b1; em_st = gbd_pkg::ST_BAD_LEN;
                      end else begin
                        st_req = 1'b1; st_total = {33'd0, t120 - {7'd0, s_new}};
                      end
                    end else begin
                      st_req = 1'b1; st_total = accum_q;
                    end
                  end else begin
                    st_req = 1'b1;
                    st_total = {32'd0, sum_q} + {40'd0, s_new} + 64'd8;
                  end
                end else if (s_new < 24'd3) begin
                  emit = 1'b1; em_st = gbd_pkg::ST_BAD_LEN;
                end else begin
                  if (kind_q == gbd_pkg::KIND_BUFR) sum_d = sum_q + {8'd0, s_new};
                  sk_req = 1'b1; sk_which = (phase_q == PH_S2LEN) ? 2'd2 : 2'd3;
                  sk_n = s_new - 24'd3;
                end
              end
            end
            PH_BODY: begin
              if (nread == accum_q[48:0] && accum_q[63:49] == '0) begin
                emit = 1'b1; em_len = accum_q[31:0];
                em_st = (trl_d >= 3'd4) ? gbd_pkg::ST_OK : gbd_pkg::ST_BAD_TRL;
              end
            end
            default: begin
              phase_d = PH_HUNT; tag_d = '0;
            end
          endcase
        end
      end
    end

    if (sk_req) begin
      if (sk_n == '0) begin
        fs_req = 1'b1; fs_which = sk_which;
      end else begin
        left_d  = sk_n;
        phase_d = (sk_which == 2'd1) ? PH_SKIP1 : ((sk_which == 2'd2) ? PH_SKIP2 : PH_SKIP3);
      end
    end
    if (fs_req) begin
      phase_d = fsec(fs_which, kind_q, flags_d);
      slen_d  = '0;
      left_d  = 24'd3;
    end
    if (st_req) begin
      emit = 1'b1; em_len = st_total[31:0];
      if ((st_total >> gbd_pkg::LENGTH_BITS) != '0) begin
        em_st = gbd_pkg::ST_TOO_LARGE;
      end else if (st_total < {15'd0, nread}) begin
        em_st = gbd_pkg::ST_BAD_LEN;
      end else if (st_total == {15'd0, nread}) begin
        accum_d = st_total;
        em_st = (trl_d >= 3'd4) ? gbd_pkg::ST_OK : gbd_pkg::ST_BAD_TRL;
      end else begin
        emit = 1'b0; accum_d = st_total; phase_d = PH_BODY;
      end
    end
    if (emit) begin
      phase_d = PH_HUNT;
      tag_d   = '0;
    end

    ok_d = ok_q; oe_d = oe_q; ol_d = ol_q; oo_d = oo_q; os_d = os_q;
    if (emit) begin
      ov_d = 1'b1;
      ok_d = em_zero ? gbd_pkg::KIND_GRIB : kind_q;
      oe_d = em_zero ? 8'd0 : ed_d;
      ol_d = em_len; oo_d = em_off; os_d = em_st;
    end else begin
      ov_d = ov_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT; tag_q <= '0; cnt_q <= '0; start_q <= '0; accum_q <= '0;
      slen_q <= '0; left_q <= '0; sum_q <= '0; flags_q <= '0; ed_q <= '0;
      kind_q <= '0; trl_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; tag_q <= tag_d; cnt_q <= cnt_d; start_q <= start_d;
      accum_q <= accum_d; slen_q <= slen_d; left_q <= left_d; sum_q <= sum_d;
      flags_q <= flags_d; ed_q <= ed_d; kind_q <= kind_d; trl_q <= trl_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d; oe_q <= oe_d; ol_q <= ol_d; oo_q <= oo_d; os_q <= os_d;
  end

  assign out_valid_o   = ov_q;
  assign msg_kind_o    = ok_q;
  assign msg_edition_o = oe_q;
  assign msg_length_o  = ol_q;
  assign msg_offset_o  = oo_q;
  assign status_o      = os_q;

  a_trl_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) trl_q <= 3'd4)
    else $error("trailer count above four");
  a_in_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HUNT) |-> ((cnt_q - start_q) >= 48'd4))
    else $error("message parse without a full tag behind it");
  a_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP1 || phase_q == PH_SKIP2 || phase_q == PH_SKIP3 ||
     phase_q == PH_S2LEN || phase_q == PH_S3LEN || phase_q == PH_S4LEN) |-> (left_q != '0))
    else $error("section countdown idle in a counting phase");
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |-> !deq_pop_o)
    else $error("request taken while a descriptor is held");

endmodule
`default_nettype wire

// File: design/grib_bufr_message_deframer_top.sv
// ---------------------------------------------------------------------------
// grib_bufr_message_deframer_top : GRIB/BUFR/TIDE/BUDG message deframer
// Front queue, parser back end and enable registers.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid_i / in_stall_o | data_byte_i, stream_end_i
//  output   | out_valid_o/out_stall_i | msg_kind_o, msg_edition_o, msg_length_o,
//           |                         | msg_offset_o, status_o
//  config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  One request per cycle sustained while neither channel stalls; a request passes the
//  two-entry queue, the parser takes one per cycle and any descriptor is registered.
//  Reset clears the queue and parser and sets both enables.
//  A stalled output with a descriptor held stops the parser; the queue absorbs up to two more requests.
// ---------------------------------------------------------------------------
`default_nettype none
module grib_bufr_message_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       msg_kind_o,
  output logic [7:0]       msg_edition_o,
  output logic [31:0]      msg_length_o,
  output logic [47:0]      msg_offset_o,
  output logic [2:0]       status_o
);

  gbd_pkg::cfg_t  cfg_q;
  gbd_pkg::item_t in_item, deq_item;
  logic           deq_valid, deq_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{grib_en: 1'b1, bufr_en: 1'b1};
    end else if (cfg_we_i) begin
      if (cfg_index_i == gbd_pkg::CFG_GRIB_EN) cfg_q.grib_en <= cfg_data_i;
      else cfg_q.bufr_en <= cfg_data_i;
    end
  end

  assign in_item.data_byte  = data_byte_i;
  assign in_item.stream_end = stream_end_i;

  gbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .deq_valid_o (deq_valid),
    .deq_pop_i   (deq_pop),
    .deq_item_o  (deq_item)
  );

  gbd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .deq_valid_i   (deq_valid),
    .deq_pop_o     (deq_pop),
    .deq_item_i    (deq_item),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .msg_kind_o    (msg_kind_o),
    .msg_edition_o (msg_edition_o),
    .msg_length_o  (msg_length_o),
    .msg_offset_o  (msg_offset_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/grib_bufr_message_deframer_top_tb.sv
// ---------------------------------------------------------------------------
// grib_bufr_message_deframer_top_tb : self-checking bench for the deframer
// Feeds byte streams of GRIB, BUFR, TIDE and BUDG messages, good and broken,
// mixed with noise and end markers. A scoreboard predicts every descriptor and
// checks each one the block gives, under random idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none
module grib_bufr_message_deframer_top_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // random part only; the directed part adds roughly another five hundred
  localparam int unsigned ITEM_GOAL   = 540;

  typedef enum int {
    PH_HUNT, PH_HEAD, PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_S2LEN, PH_S3LEN, PH_S4LEN, PH_BODY
  } parse_phase_e;

  typedef enum int {
    F_GRIB1, F_GRIB1_BIG, F_GRIB2, F_BUFR_OLD, F_BUFR_NEW, F_TIDE, F_BUDG
  } msg_form_e;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  edition;
    logic [31:0] length;
    logic [47:0] offset;
    logic [2:0]  status;
  } descriptor_t;

  class deframer_scoreboard;
    logic        grib_en, bufr_en;
    logic [31:0] tag_shift;
    parse_phase_e phase;
    logic [47:0] byte_cnt, msg_start;
    logic [63:0] len_acc;
    logic [23:0] sec_len;
    logic [31:0] sec_sum, left;
    logic [7:0]  flags, edition;
    logic [1:0]  kind;
    logic [2:0]  sevens;
    descriptor_t pending_desc[$];
    int unsigned mismatches, checked;

    function new();
      grib_en = 1'b1; bufr_en = 1'b1;
      tag_shift = '0; phase = PH_HUNT; byte_cnt = '0; msg_start = '0;
      len_acc = '0; sec_len = '0; sec_sum = '0; left = '0; flags = '0;
      edition = '0; kind = gbd_pkg::KIND_GRIB; sevens = '0;
      mismatches = 0; checked = 0;
    endfunction

    function void push_desc(logic [1:0] k, logic [7:0] ed, logic [63:0] len,
                            logic [47:0] off, logic [2:0] st);
      descriptor_t d;
      d.kind = k; d.edition = ed; d.length = len[31:0]; d.offset = off; d.status = st;
      pending_desc.push_back(d);
    endfunction

    function void emit(logic [2:0] st, logic [63:0] len);
      push_desc(kind, edition, len, msg_start, st);
      phase = PH_HUNT;
      tag_shift = '0;
    endfunction

    function void set_total(logic [63:0] total, logic [63:0] nread);
      logic [63:0] lim;
      lim = ((64'd1 << (gbd_pkg::LENGTH_BITS - 1)) << 1) - 64'd1;
      if (total > lim) emit(gbd_pkg::ST_TOO_LARGE, total);
      else if (total < nread) emit(gbd_pkg::ST_BAD_LEN, total);
      else begin
        len_acc = total;
        if (total == nread)
          emit((sevens >= 3'd4) ? gbd_pkg::ST_OK : gbd_pkg::ST_BAD_TRL, len_acc);
        else phase = PH_BODY;
      end
    endfunction

    function void start_len(parse_phase_e p);
      phase = p;
      sec_len = '0;
      left = 32'd3;
    endfunction

    function void finish_section(int which);
      if (kind >= gbd_pkg::KIND_TIDE || which == 3) start_len(PH_S4LEN);
      else if (which == 1 && flags[7]) start_len(PH_S2LEN);
      else if (kind == gbd_pkg::KIND_BUFR || flags[6]) start_len(PH_S3LEN);
      else start_len(PH_S4LEN);
    endfunction

    function void begin_skip(int which, logic [31:0] n);
      if (n == 0) finish_section(which);
      else begin
        left = n;
        phase = (which == 1) ? PH_SKIP1 : ((which == 2) ? PH_SKIP2 : PH_SKIP3);
      end
    endfunction

    function void note_input(logic [7:0] b, logic fin);
      logic [47:0] cur, pos;
      logic [63:0] nread, t;
      logic [31:0] s;
      if (fin) begin
        if (phase == PH_HUNT) begin
          push_desc(gbd_pkg::KIND_GRIB, 8'd0, 64'd0, byte_cnt, gbd_pkg::ST_NO_MSG);
          tag_shift = '0;
        end else emit(gbd_pkg::ST_PREMATURE, (phase == PH_BODY) ? len_acc : 64'd0);
        return;
      end
      cur = byte_cnt;
      byte_cnt = cur + 48'd1;
      if (phase == PH_HUNT) begin
        tag_shift = {tag_shift[23:0], b};
        if (tag_shift == gbd_pkg::TAG_GRIB && grib_en) kind = gbd_pkg::KIND_GRIB;
        else if (tag_shift == gbd_pkg::TAG_BUFR && bufr_en) kind = gbd_pkg::KIND_BUFR;
        else if (tag_shift == gbd_pkg::TAG_TIDE && grib_en) kind = gbd_pkg::KIND_TIDE;
        else if (tag_shift == gbd_pkg::TAG_BUDG && grib_en) kind = gbd_pkg::KIND_BUDG;
        else return;
        msg_start = cur - 48'd3;
        phase = PH_HEAD;
        len_acc = '0; sec_len = '0; sec_sum = '0; flags = '0;
        edition = '0; sevens = '0; left = '0;
        return;
      end
      pos = cur - msg_start;
      nread = {16'd0, pos} + 64'd1;
      if (b == gbd_pkg::CHAR_7) begin
        if (sevens < 3'd4) sevens++;
      end else sevens = '0;
      case (phase)
        PH_HEAD: begin
          if (kind >= gbd_pkg::KIND_TIDE) begin
            if (pos <= 6) begin
              sec_len = {sec_len[15:0], b};
              if (pos == 6) begin
                s = {8'd0, sec_len};
                if (s + 32'd7 > gbd_pkg::HEADER_LIMIT) emit(gbd_pkg::ST_HDR_LONG, 64'd0);
                else if (s < 3) emit(gbd_pkg::ST_BAD_LEN, 64'd0);
                else begin
                  sec_sum = s;
                  begin_skip(1, s - 32'd3);
                end
              end
            end
          end else if (pos <= 6) len_acc = {len_acc[55:0], b};
          else if (pos == 7) begin
            edition = b;
            if (kind == gbd_pkg::KIND_GRIB) begin
              if (b == 8'd1) begin
                if (!len_acc[23]) set_total(len_acc, nread);
                else sec_len = '0;
              end else if (b == 8'd2) len_acc = '0;
              else emit(gbd_pkg::ST_BAD_ED, 64'd0);
            end else if (b >= 8'd2) set_total(len_acc, nread);
          end else if (kind == gbd_pkg::KIND_GRIB && edition == 8'd2) begin
            len_acc = {len_acc[55:0], b};
            if (pos == 15) set_total(len_acc, nread);
          end else if (kind == gbd_pkg::KIND_GRIB) begin
            if (pos <= 10) sec_len = {sec_len[15:0], b};
            else if (pos == 15) begin
              flags = b;
              s = {8'd0, sec_len};
              if (s < 8) emit(gbd_pkg::ST_BAD_LEN, 64'd0);
              else begin_skip(1, s - 32'd8);
            end
          end else if (pos == 11) begin
            flags = b;
            s = {8'd0, len_acc[23:0]};
            if (s < 8) emit(gbd_pkg::ST_BAD_LEN, 64'd0);
            else begin
              sec_sum = s;
              begin_skip(1, s - 32'd8);
            end
          end
        end
        PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
          if (left != 0) left--;
          if (left == 0)
            finish_section((phase == PH_SKIP1) ? 1 : ((phase == PH_SKIP2) ? 2 : 3));
        end
        PH_S2LEN, PH_S3LEN, PH_S4LEN: begin
          sec_len = {sec_len[15:0], b};
          if (left != 0) left--;
          if (left == 0) begin
            s = {8'd0, sec_len};
            if (phase == PH_S4LEN) begin
              if (kind == gbd_pkg::KIND_GRIB) begin
                if (s < 120) begin
                  t = {41'd0, len_acc[22:0]} * 64'd120 + 64'd4;
                  if (t < {32'd0, s}) emit(gbd_pkg::ST_BAD_LEN, 64'd0);
                  else set_total(t - {32'd0, s}, nread);
                end else set_total(len_acc, nread);
              end else set_total({32'd0, sec_sum} + {32'd0, s} + 64'd8, nread);
            end else if (s < 3) emit(gbd_pkg::ST_BAD_LEN, 64'd0);
            else begin
              if (kind == gbd_pkg::KIND_BUFR) sec_sum += s;
              begin_skip((phase == PH_S2LEN) ? 2 : 3, s - 32'd3);
            end
          end
        end
        PH_BODY: begin
          if (nread == len_acc)
            emit((sevens >= 3'd4) ? gbd_pkg::ST_OK : gbd_pkg::ST_BAD_TRL, len_acc);
        end
        default: begin
          phase = PH_HUNT;
          tag_shift = '0;
        end
      endcase
    endfunction

    function void check_result(descriptor_t got);
      descriptor_t want;
      checked++;
      if (pending_desc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("descriptor with none predicted: kind %0d ed %0d len %0d off %0d st %0d",
                   got.kind, got.edition, got.length, got.offset, got.status);
        return;
      end
      want = pending_desc.pop_front();
      if (got.kind !== want.kind || got.edition !== want.edition ||
          got.length !== want.length || got.offset !== want.offset ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("descriptor mismatch: exp kind %0d ed %0d len %0d off %0d st %0d",
                   want.kind, want.edition, want.length, want.offset, want.status);
          $display("                     got kind %0d ed %0d len %0d off %0d st %0d",
                   got.kind, got.edition, got.length, got.offset, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_index_i, cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [7:0]  data_byte_i;
  logic        stream_end_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  msg_kind_o;
  logic [7:0]  msg_edition_o;
  logic [31:0] msg_length_o;
  logic [47:0] msg_offset_o;
  logic [2:0]  status_o;

  grib_bufr_message_deframer_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .data_byte_i, .stream_end_i,
    .out_valid_o, .out_stall_i, .msg_kind_o, .msg_edition_o,
    .msg_length_o, .msg_offset_o, .status_o
  );

  deframer_scoreboard sb = new();
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned items_sent = 0, msgs_sent = 0, cycle_cnt = 0;
  logic [7:0] msg_q[$];

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL grib_bufr_message_deframer_top");
      $finish;
    end
  end

  // Receiver stall and result check.
  always @(posedge clk_i) begin
    descriptor_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind = msg_kind_o; got.edition = msg_edition_o; got.length = msg_length_o;
      got.offset = msg_offset_o; got.status = status_o;
      sb.check_result(got);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(logic [7:0] b, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    stream_end_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b, fin);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_desc.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gbd_pkg::CFG_GRIB_EN) sb.grib_en = val;
    else sb.bufr_en = val;
  endtask

  task automatic put24(int unsigned v);
    msg_q.push_back(v[23:16]); msg_q.push_back(v[15:8]); msg_q.push_back(v[7:0]);
  endtask

  task automatic put_tag(logic [31:0] tag);
    for (int i = 3; i >= 0; i--) msg_q.push_back(tag[8*i +: 8]);
  endtask

  task automatic fill(int n);
    for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom_range(255)));
  endtask

  // Fill to the total, ending in the trailer; nothing if already past it.
  task automatic pad_to(int unsigned total);
    while (msg_q.size() + 4 < total) msg_q.push_back(8'($urandom_range(255)));
    while (msg_q.size() < total) msg_q.push_back(gbd_pkg::CHAR_7);
  endtask

  // twist 0 builds a well-formed message; other values may break it in one way, depending on the form.
  task automatic build_msg(msg_form_e form, int twist);
    int unsigned s1, s2, s3, v, total;
    logic [7:0] fl;
    logic [63:0] big;
    msg_q = {};
    case (form)
      F_GRIB1: begin
        put_tag(gbd_pkg::TAG_GRIB);
        total = (twist == 1) ? $urandom_range(0, 7) : $urandom_range(12, 70);
        put24(total);
        msg_q.push_back((twist == 2) ? 8'($urandom_range(3, 255)) : 8'd1);
        pad_to(total);
      end
      F_GRIB1_BIG: begin
        put_tag(gbd_pkg::TAG_GRIB);
        put24(24'h800001);
        msg_q.push_back(8'd1);
        s1 = (twist == 1) ? $urandom_range(0, 7) : $urandom_range(8, 12);
        put24(s1);
        fill(4);
        fl = 8'($urandom_range(255));
        msg_q.push_back(fl);
        if (s1 >= 8) begin
          fill(s1 - 8);
          if (fl[7]) begin
            s2 = (twist == 2) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            put24(s2);
            if (s2 >= 3) fill(s2 - 3);
          end
          if (fl[6]) begin
            s3 = $urandom_range(3, 6);
            put24(s3);
            fill(s3 - 3);
          end
          total = msg_q.size() + 3 + $urandom_range(4, 20);
          if (twist == 3) total = msg_q.size() + 3 - $urandom_range(1, 3);
          put24(124 - total);
          pad_to(total);
        end
      end
      F_GRIB2: begin
        put_tag(gbd_pkg::TAG_GRIB);
        fill(3);
        msg_q.push_back(8'd2);
        if (twist == 1) big = {32'($urandom_range(1, 65535)), 32'($urandom)};
        else if (twist == 2) big = 64'($urandom_range(0, 15));
        else big = 64'($urandom_range(16, 70));
        for (int i = 7; i >= 0; i--) msg_q.push_back(big[8*i +: 8]);
        // an oversized total ends the message at its header
        if (twist != 1) pad_to(big[31:0]);
      end
      F_BUFR_OLD: begin
        put_tag(gbd_pkg::TAG_BUFR);
        s1 = (twist == 1) ? $urandom_range(0, 7) : $urandom_range(8, 14);
        put24(s1);
        msg_q.push_back(8'($urandom_range(0, 1)));
        fill(3);
        fl = 8'($urandom_range(255));
        msg_q.push_back(fl);
        if (s1 >= 8) begin
          fill(s1 - 8);
          s2 = 0;
          if (fl[7]) begin
            s2 = $urandom_range(3, 8);
            put24(s2);
            fill(s2 - 3);
          end
          s3 = (twist == 2) ? $urandom_range(0, 2) : $urandom_range(3, 8);
          put24(s3);
          if (s3 >= 3) begin
            fill(s3 - 3);
            v = $urandom_range(3, 25);
            put24(v);
            pad_to(s1 + s2 + s3 + v + 8);
          end
        end
      end
      F_BUFR_NEW: begin
        put_tag(gbd_pkg::TAG_BUFR);
        total = (twist == 1) ? $urandom_range(0, 7) : $urandom_range(8, 70);
        put24(total);
        msg_q.push_back(8'($urandom_range(2, 255)));
        pad_to(total);
      end
      default: begin
        put_tag((form == F_TIDE) ? gbd_pkg::TAG_TIDE : gbd_pkg::TAG_BUDG);
        if (twist == 1) s1 = $urandom_range(26, 300);
        else if (twist == 2) s1 = $urandom_range(0, 2);
        else s1 = $urandom_range(3, 25);
        put24(s1);
        if (s1 >= 3 && s1 <= 25) begin
          fill(s1 - 3);
          v = $urandom_range(0, 30);
          put24(v);
          pad_to(s1 + v + 8);
        end
      end
    endcase
    if (twist == 4) msg_q[msg_q.size() - 1] = 8'($urandom_range(255));
  endtask

  // Send the built message; cut it short with an end marker when asked.
  task automatic send_msg(int cut);
    for (int i = 0; i < msg_q.size(); i++) begin
      if (i == cut) begin
        send_item(8'd0, 1'b1);
        return;
      end
      send_item(msg_q[i], 1'b0);
    end
    msgs_sent++;
  endtask

  task automatic random_traffic(int unsigned goal);
    int unsigned r;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 12) begin
        repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(255)), 1'b0);
      end else if (r < 16) send_item(8'($urandom_range(255)), 1'b1);
      else begin
        build_msg(msg_form_e'($urandom_range(0, 6)),
                  ($urandom_range(99) < 25) ? $urandom_range(1, 4) : 0);
        send_msg(($urandom_range(99) < 8) ? $urandom_range(0, msg_q.size() - 1) : -1);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = gbd_pkg::CFG_GRIB_EN; cfg_data_i = 1'b0;
    in_valid_i = 1'b0; data_byte_i = '0; stream_end_i = 1'b0; out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34; recv_idle_pct = 68;
    // Directed: field extremes, end while hunting, each length rule and error.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    for (int f = 0; f <= 6; f++) begin
      build_msg(msg_form_e'(f), 0);
      send_msg(-1);
    end
    build_msg(F_GRIB1, 2); send_msg(-1);
    build_msg(F_GRIB2, 1); send_msg(-1);
    build_msg(F_GRIB2, 2); send_msg(-1);
    build_msg(F_GRIB1_BIG, 1); send_msg(-1);
    build_msg(F_GRIB1_BIG, 3); send_msg(-1);
    build_msg(F_BUFR_OLD, 2); send_msg(-1);
    build_msg(F_TIDE, 1); send_msg(-1);
    build_msg(F_BUDG, 2); send_msg(-1);
    build_msg(F_BUFR_NEW, 4); send_msg(-1);
    build_msg(F_GRIB2, 0); send_msg(12);
    build_msg(F_GRIB1, 0); send_msg(20);
    drain();

    random_traffic(items_sent + ITEM_GOAL / 3);
    send_item(8'd0, 1'b1);
    drain();

    write_cfg(gbd_pkg::CFG_GRIB_EN, 1'b0);
    send_idle_pct = 68; recv_idle_pct = 34;
    random_traffic(items_sent + ITEM_GOAL / 6);
    send_item(8'd0, 1'b1);
    drain();
    write_cfg(gbd_pkg::CFG_GRIB_EN, 1'b1);
    write_cfg(gbd_pkg::CFG_BUFR_EN, 1'b0);
    random_traffic(items_sent + ITEM_GOAL / 6);
    send_item(8'd0, 1'b1);
    drain();
    write_cfg(gbd_pkg::CFG_GRIB_EN, 1'b0);
    random_traffic(items_sent + 60);
    send_item(8'd0, 1'b1);
    drain();

    write_cfg(gbd_pkg::CFG_GRIB_EN, 1'b1);
    write_cfg(gbd_pkg::CFG_BUFR_EN, 1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_traffic(items_sent + ITEM_GOAL / 3);
    send_item(8'd0, 1'b1);
    in_valid_i <= 1'b0;
    while (sb.pending_desc.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests, %0d whole messages, %0d descriptors checked",
             items_sent, msgs_sent, sb.checked);
    $display("enable settings on, GRIB off, BUFR off and both off, under three idle mixes");
    if (sb.mismatches == 0 && sb.pending_desc.size() == 0) begin
      $display("PASS grib_bufr_message_deframer_top");
    end else begin
      $display("%0d mismatches, %0d descriptors missing",
               sb.mismatches, sb.pending_desc.size());
      $display("FAIL grib_bufr_message_deframer_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
